// ===== hw/rtl/mpeg2iq_pkg.sv =====
// ---------------------------------------------------------------------------
// mpeg2iq_pkg
// Shared constants for the MPEG-2 inverse quantizer: item kinds, weight
// memory geometry and register map.
// ---------------------------------------------------------------------------
package mpeg2iq_pkg;

   localparam int BLOCK_COEFFS        = 64;
   localparam int POS_BITS            = $clog2(BLOCK_COEFFS);
   localparam int WEIGHT_BITS         = 8;
   localparam int VALUE_BITS          = 16;
   localparam int COEFF_BITS_DEFAULT  = 16;

   // intra table in the lower half, inter table in the upper half
   localparam int WMEM_DEPTH     = 2 * BLOCK_COEFFS;
   localparam int WMEM_ADDR_BITS = $clog2(WMEM_DEPTH);

   typedef logic [1:0] kind_type;
   localparam kind_type KIND_LOAD_INTRA  = 2'd0;
   localparam kind_type KIND_LOAD_INTER  = 2'd1;
   localparam kind_type KIND_INTRA_COEFF = 2'd2;
   localparam kind_type KIND_INTER_COEFF = 2'd3;

   localparam int CSR_ADDR_BITS = 3;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_ALT_SCAN_ADDR = 3'd0;

endpackage

// ===== hw/rtl/mpeg2iq_wmem.sv =====
// ---------------------------------------------------------------------------
// mpeg2iq_wmem
// Weight table memory: intra and inter tables in one array, one write and
// one read port, read data registered.
// ---------------------------------------------------------------------------
module mpeg2iq_wmem
   import mpeg2iq_pkg::*;
(
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [WMEM_ADDR_BITS-1:0] wr_addr,
   input  logic [WEIGHT_BITS-1:0]    wr_data,
   input  logic                      rd_en,
   input  logic [WMEM_ADDR_BITS-1:0] rd_addr,
   output logic [WEIGHT_BITS-1:0]    rd_data
);

   logic [WEIGHT_BITS-1:0] mem [WMEM_DEPTH];
   logic [WEIGHT_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/mpeg2_inverse_quantizer.sv =====
// ---------------------------------------------------------------------------
// mpeg2_inverse_quantizer
// MPEG-2 inverse quantization with mismatch control.
// ---------------------------------------------------------------------------
// A weight load beat writes one entry of the intra or inter weight table
// when it is taken, so loads can follow back to back. A coefficient beat
// passes through the steps below into the result register. The weight
// memory is read at the accept edge. Then come the quant_scale x weight
// multiply, the level x scale multiply, and the sign, wrap and parity fold
// into the output register. The input stalls until that last step is done,
// so no new coefficient is taken while one is in process. A stalled result
// in the output register delays the fold and adds its stall cycles. Once the
// result is in the output register, the next beat is taken, and the register
// can hold the result while the next coefficient is processed. Weight table
// entries read before they are loaded give undefined results. The mismatch
// parity is reloaded by the inter coefficient at position 0 and folded into
// position 63.
// ---------------------------------------------------------------------------
module mpeg2_inverse_quantizer
   import mpeg2iq_pkg::*;
#(
   parameter int COEFF_BITS = COEFF_BITS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   // input beats
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [1:0]                     req_kind,
   input  logic [POS_BITS-1:0]            req_position,
   input  logic signed [VALUE_BITS-1:0]   req_coeff_value,
   input  logic [6:0]                     req_quant_scale,
   input  logic [3:0]                     req_dc_scale,
   input  logic                           req_past_last,
   // result beats
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic signed [VALUE_BITS-1:0]   rsp_result_value,
   output logic [POS_BITS-1:0]            rsp_result_position,
   // register port
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [CSR_ADDR_BITS-1:0]       paddr,
   input  logic [31:0]                    pwdata,
   output logic [31:0]                    prdata,
   output logic                           pready
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_WGT  = 2'd1;
   localparam logic [1:0] ST_MUL  = 2'd2;
   localparam logic [1:0] ST_FIN  = 2'd3;

   localparam logic [POS_BITS-1:0] POS_LAST = POS_BITS'(BLOCK_COEFFS - 1);

   // ---- register port ----
   logic alt_scan_ff, alt_scan_in;
   logic csr_wr;

   assign pready = 1'b1;
   assign csr_wr = psel & penable & pwrite;
   assign alt_scan_in = (csr_wr && paddr == CSR_ALT_SCAN_ADDR) ? pwdata[0] : alt_scan_ff;
   assign prdata = (paddr == CSR_ALT_SCAN_ADDR) ? {31'd0, alt_scan_ff} : 32'd0;

   // ---- control ----
   logic [1:0] state_ff, state_in;
   logic       accept;
   logic       is_load;
   logic       is_coeff_accept;
   logic       out_free;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid & ~req_stall;
   assign is_load   = (req_kind == KIND_LOAD_INTRA) || (req_kind == KIND_LOAD_INTER);
   assign is_coeff_accept = accept & ~is_load;
   assign out_free  = ~rsp_valid | ~rsp_stall;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (is_coeff_accept) state_in = ST_WGT;
         ST_WGT:  state_in = ST_MUL;
         ST_MUL:  state_in = ST_FIN;
         ST_FIN:  if (out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // ---- weight memory ----
   logic [WEIGHT_BITS-1:0]    weight;
   logic [WMEM_ADDR_BITS-1:0] wmem_addr;

   // kind bit 0 selects the inter table for both loads and coefficients
   assign wmem_addr = {req_kind[0], req_position};

   mpeg2iq_wmem u_wmem (
      .clock   (clock),
      .wr_en   (accept & is_load),
      .wr_addr (wmem_addr),
      .wr_data (req_coeff_value[WEIGHT_BITS-1:0]),
      .rd_en   (is_coeff_accept),
      .rd_addr (wmem_addr),
      .rd_data (weight)
   );

   // ---- item capture ----
   logic                  inter_ff, dc_ff, neg_ff, proc_ff;
   logic [POS_BITS-1:0]   pos_ff;
   logic [VALUE_BITS-1:0] raw_ff;
   logic [6:0]            qs_ff;
   logic [3:0]            dcs_ff;
   logic [16:0]           op_ff, op_in;
   logic [VALUE_BITS-1:0] mag;
   logic                  inter_in, dc_in, proc_in;

   assign inter_in = (req_kind == KIND_INTER_COEFF);
   assign dc_in    = (req_kind == KIND_INTRA_COEFF) && (req_position == '0);
   assign mag      = req_coeff_value[VALUE_BITS-1] ?
                     (VALUE_BITS'(0) - VALUE_BITS'(req_coeff_value)) :
                     VALUE_BITS'(req_coeff_value);
   // intra DC is always scaled; zeros come out as zero anyway
   assign proc_in  = dc_in |
                     ((req_coeff_value != '0) && (!req_past_last || alt_scan_ff));
   // inter uses 2|v|+1
   assign op_in    = inter_in ? {mag, 1'b1} : {1'b0, mag};

   always_ff @(posedge clock) begin
      if (is_coeff_accept) begin
         inter_ff <= inter_in;
         dc_ff    <= dc_in;
         neg_ff   <= req_coeff_value[VALUE_BITS-1];
         proc_ff  <= proc_in;
         pos_ff   <= req_position;
         raw_ff   <= VALUE_BITS'(req_coeff_value);
         qs_ff    <= req_quant_scale;
         dcs_ff   <= req_dc_scale;
         op_ff    <= op_in;
      end
   end

   // ---- multiply stages ----
   logic [14:0] scale_ff, scale_in;
   logic [31:0] prod_ff, prod_in;

   assign scale_in = dc_ff ? {11'd0, dcs_ff} : (15'(qs_ff) * 15'(weight));
   assign prod_in  = 32'(op_ff) * 32'(scale_ff);

   always_ff @(posedge clock) begin
      if (state_ff == ST_WGT) begin
         scale_ff <= scale_in;
      end
      if (state_ff == ST_MUL) begin
         prod_ff <= prod_in;
      end
   end

   // ---- finish: sign, wrap, mismatch parity ----
   logic                  parity_ff, parity_in;
   logic [31:0]           shifted;
   logic [31:0]           signed_val;
   logic [VALUE_BITS-1:0] low_val;
   logic [VALUE_BITS-1:0] wrapped;
   logic                  par_base, par_new;
   logic [VALUE_BITS-1:0] fin_val;
   logic                  fin_done;

   always_comb begin
      if (dc_ff) begin
         shifted = prod_ff;
      end else if (inter_ff) begin
         shifted = prod_ff >> 4;
      end else begin
         shifted = prod_ff >> 3;
      end
      signed_val = neg_ff ? (32'd0 - shifted) : shifted;
      low_val    = proc_ff ? signed_val[VALUE_BITS-1:0] : raw_ff;
      for (int i = 0; i < VALUE_BITS; i++) begin
         wrapped[i] = (i < COEFF_BITS) ? low_val[i] : low_val[COEFF_BITS-1];
      end
      par_base = (pos_ff == '0) ? 1'b1 : parity_ff;
      par_new  = proc_ff ? (par_base ^ wrapped[0]) : par_base;
      fin_val  = wrapped;
      if (inter_ff && pos_ff == POS_LAST) begin
         fin_val[0] = wrapped[0] ^ par_new;
      end
   end

   assign fin_done  = (state_ff == ST_FIN) && out_free;
   assign parity_in = (fin_done && inter_ff) ? par_new : parity_ff;

   // ---- output register ----
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [VALUE_BITS-1:0] rsp_value_ff;
   logic [POS_BITS-1:0]   rsp_pos_ff;

   assign rsp_valid_in = fin_done ? 1'b1 : (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (fin_done) begin
         rsp_value_ff <= fin_val;
         rsp_pos_ff   <= pos_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         parity_ff    <= 1'b1;
         alt_scan_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         parity_ff    <= parity_in;
         alt_scan_ff  <= alt_scan_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_result_value    = signed'(rsp_value_ff);
   assign rsp_result_position = rsp_pos_ff;

endmodule
